// File: rtl/rca_pkg.sv
package rca_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int MIN_CELLS  = 5;
  localparam int ROW_W      = MAX_CELLS;
  localparam int LEN_W      = 7;
  localparam int COUNT_W    = 7;
  localparam int LANE_CELLS = 8;
  localparam int LANES      = MAX_CELLS / LANE_CELLS;
  localparam int WIN_W      = LANE_CELLS + 4;
  localparam int LCNT_W     = $clog2(LANE_CELLS + 1);
  localparam int IDX_W      = $clog2(MAX_CELLS);
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  typedef enum logic {
    RULE_RADIUS2 = 1'b0,
    RULE_ELEM126 = 1'b1
  } rule_t;

  typedef enum logic {
    REG_RULE_SELECT = 1'b0,
    REG_ROW_LENGTH  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  // cells that wrap around the ring ends
  typedef struct packed {
    logic cell0;
    logic cell1;
    logic top1;
    logic top2;
  } wrap_t;

  // per-lane control
  typedef struct packed {
    rule_t            rule;
    mode_t            mode;
    logic [LEN_W-1:0] len;
    wrap_t            wrap;
  } lane_ctl_t;

  typedef struct packed {
    logic [LANE_CELLS-1:0] bits;
    logic [LCNT_W-1:0]     cnt;
  } lane_res_t;

endpackage

// File: rtl/rca_in_if.sv
interface rca_in_if;
  import rca_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [ROW_W-1:0] row_in;

  modport source (output valid, output mode, output row_in, input ready);
  modport sink   (input valid, input mode, input row_in, output ready);
endinterface

// File: rtl/rca_out_if.sv
interface rca_out_if;
  import rca_pkg::*;

  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_out;
  logic [COUNT_W-1:0] live_count;
  logic               all_dead;

  modport source (output valid, output row_out, output live_count, output all_dead,
                  input ready);
  modport sink   (input valid, input row_out, input live_count, input all_dead,
                  output ready);
endinterface

// File: rtl/rca_lane.sv
module rca_lane (
  input  logic [rca_pkg::WIN_W-1:0]      win,
  input  logic [rca_pkg::LEN_W-1:0]      base,
  input  logic [rca_pkg::LANE_CELLS-1:0] load_bits,
  input  rca_pkg::lane_ctl_t             ctl,
  output rca_pkg::lane_res_t             res
);
  import rca_pkg::*;

  always_comb begin
    logic [LEN_W-1:0] g;
    logic             l2, l1, c, r1, r2;
    logic [2:0]       s3, s5;
    logic             alive;
    logic [LCNT_W-1:0] cnt;
    res  = '0;
    cnt  = '0;
    for (int j = 0; j < LANE_CELLS; j++) begin
      g  = base + LEN_W'(j);
      c  = win[j+2];
      // wrap left neighbors to the top of the active row
      l1 = (g == '0) ? ctl.wrap.top1 : win[j+1];
      l2 = (g == '0) ? ctl.wrap.top2 :
           (g == LEN_W'(1)) ? ctl.wrap.top1 : win[j];
      // wrap right neighbors to the bottom of the ring
      r1 = (g + LEN_W'(1) == ctl.len) ? ctl.wrap.cell0 : win[j+3];
      r2 = (g + LEN_W'(2) == ctl.len) ? ctl.wrap.cell0 :
           (g + LEN_W'(1) == ctl.len) ? ctl.wrap.cell1 : win[j+4];
      s3 = 3'(l1) + 3'(c) + 3'(r1);
      s5 = s3 + 3'(l2) + 3'(r2);
      unique case (ctl.rule)
        RULE_RADIUS2: alive = (s5 == 3'd2) || (s5 == 3'd4);
        RULE_ELEM126: alive = (s3 == 3'd1) || (s3 == 3'd2);
        default:      alive = 1'b0;
      endcase
      if (ctl.mode == MODE_LOAD) begin
        alive = load_bits[j];
      end
      res.bits[j] = alive && (g < ctl.len);
      cnt = cnt + LCNT_W'(res.bits[j]);
    end
    res.cnt = cnt;
  end

endmodule

// File: rtl/rca_merge.sv
module rca_merge (
  input  rca_pkg::lane_res_t [rca_pkg::LANES-1:0] lane_res,
  output logic [rca_pkg::ROW_W-1:0]               row,
  output logic [rca_pkg::COUNT_W-1:0]             live_count,
  output logic                                    all_dead
);
  import rca_pkg::*;

  always_comb begin
    logic [COUNT_W-1:0] sum;
    sum = '0;
    row = '0;
    for (int k = 0; k < LANES; k++) begin
      row[k*LANE_CELLS +: LANE_CELLS] = lane_res[k].bits;
      sum = sum + COUNT_W'(lane_res[k].cnt);
    end
    live_count = sum;
    all_dead   = (sum == '0);
  end

endmodule

// File: rtl/ring_cellular_automaton_unit.sv
// Ring cellular automaton on a circular row of up to MAX_CELLS cells.
//
// Input channel (in_ch): each transfer carries mode and row_in. Mode load
// writes the row from row_in, masked to the active length; mode step advances
// the stored row by one generation, all cells at once, wrapping at the
// active length. Output channel (out_ch): one transfer per input item with
// the new row, its live-cell count and an all-dead flag.
// The result is registered: it is in the output register on the cycle
// after the input transfer. Throughput is one item per cycle when out_ch
// is not stalled; the next generation depends only on the stored row.
// Eight lanes of eight cells compute the next row and lane counts, and a
// merge stage sums the counts.
// When the receiver stalls, the result holds and in_ch.ready drops; an input
// is taken in the same cycle as the waiting result is taken.
// Configuration (APB, write only while idle): rule_select at byte 0,
// row_length at byte 4; lengths below 5 act as 5, above 64 as 64.
// Reset (synchronous, rst_n low) clears the row, drops out_ch.valid and sets
// rule_select to 1 and row_length to 64.
module ring_cellular_automaton_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  rca_in_if.sink                      in_ch,
  rca_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rca_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [rca_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [rca_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import rca_pkg::*;

  // configuration registers
  rule_t            rule_r, rule_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // row state and output register
  logic [ROW_W-1:0]   cell_row_r, cell_row_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]   out_row_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_dead_r;

  logic               in_xfer;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [LEN_W-1:0]   act_len;
  lane_ctl_t          ctl;
  logic [WIN_W-1:0]   win [LANES];
  lane_res_t [LANES-1:0] lane_res;
  logic [ROW_W-1:0]   new_row;
  logic [COUNT_W-1:0] new_count;
  logic               new_dead;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    rule_nxt   = rule_r;
    len_nxt    = len_r;
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_RULE_SELECT: begin
        cfg_prdata = CFG_DW'(rule_r);
        if (cfg_wr) begin
          rule_nxt = rule_t'(cfg_pwdata[0]);
        end
      end
      REG_ROW_LENGTH: begin
        cfg_prdata = CFG_DW'(len_r);
        if (cfg_wr) begin
          len_nxt = cfg_pwdata[LEN_W-1:0];
        end
      end
      default: cfg_prdata = '0;
    endcase
  end

  // clamp length into the supported range
  always_comb begin
    if (len_r < LEN_W'(MIN_CELLS)) begin
      act_len = LEN_W'(MIN_CELLS);
    end else if (len_r > LEN_W'(MAX_CELLS)) begin
      act_len = LEN_W'(MAX_CELLS);
    end else begin
      act_len = len_r;
    end
  end

  // ----------------------------------------------------------------- lanes
  always_comb begin
    logic [IDX_W-1:0] t1, t2;
    t1 = IDX_W'(act_len - LEN_W'(1));
    t2 = IDX_W'(act_len - LEN_W'(2));
    ctl.rule       = rule_r;
    ctl.mode       = mode_t'(in_ch.mode);
    ctl.len        = act_len;
    ctl.wrap.cell0 = cell_row_r[0];
    ctl.wrap.cell1 = cell_row_r[1];
    ctl.wrap.top1  = cell_row_r[t1];
    ctl.wrap.top2  = cell_row_r[t2];
  end

  // neighbor window for each lane: two cells below the lane to two cells above it
  always_comb begin
    int idx;
    for (int k = 0; k < LANES; k++) begin
      for (int w = 0; w < WIN_W; w++) begin
        idx = k * LANE_CELLS + w - 2;
        if (idx >= 0 && idx < ROW_W) begin
          win[k][w] = cell_row_r[IDX_W'(idx)];
        end else begin
          win[k][w] = 1'b0;
        end
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    rca_lane u_lane (
      .win       (win[k]),
      .base      (LEN_W'(k * LANE_CELLS)),
      .load_bits (in_ch.row_in[k*LANE_CELLS +: LANE_CELLS]),
      .ctl       (ctl),
      .res       (lane_res[k])
    );
  end

  rca_merge u_merge (
    .lane_res   (lane_res),
    .row        (new_row),
    .live_count (new_count),
    .all_dead   (new_dead)
  );

  // ------------------------------------------------------------- handshake
  // take a new item whenever the output register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    cell_row_nxt  = cell_row_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      cell_row_nxt  = new_row;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r      <= RULE_ELEM126;
      len_r       <= LEN_W'(MAX_CELLS);
      cell_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rule_r      <= rule_nxt;
      len_r       <= len_nxt;
      cell_row_r  <= cell_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the payload until the next transfer in
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_row_r   <= new_row;
      out_count_r <= new_count;
      out_dead_r  <= new_dead;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_out    = out_row_r;
  assign out_ch.live_count = out_count_r;
  assign out_ch.all_dead   = out_dead_r;

endmodule
